// ===== rtl/u8t_pkg.sv =====
// Package for the 8N1 serial transceiver core.
// Holds widths, reset constants and the result structs shared by the
// transmitter, the receiver and the top level. Depends on nothing.
package u8t_pkg;

	localparam int CPB_W     = 16;
	localparam int ELAPSED_W = 20;
	localparam int IDX_W     = 4;
	localparam int BYTE_W    = 8;

	localparam logic [CPB_W-1:0]     CPB_RESET   = 16'd6076;
	localparam logic [CPB_W-1:0]     CPB_MIN     = 16'd2;
	localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = 20'hFFFFF;

	// Transmitter status after one tick.
	typedef struct packed {
		logic level;
		logic busy;
	} tx_res_t;

	// Receiver report for one tick.
	typedef struct packed {
		logic              valid;
		logic [BYTE_W-1:0] data;
		logic              ferr;
	} rx_res_t;

endpackage

// ===== rtl/u8t_if.sv =====
// Valid/ready stream interfaces for the 8N1 serial transceiver core.
// One carries the per-tick input item, the other the per-tick result.
// Depends on nothing.
interface u8t_item_if;
	logic       valid;
	logic       ready;
	logic       rx_level;
	logic       send_valid;
	logic [7:0] send_byte;

	modport source (output valid, rx_level, send_valid, send_byte, input ready);
	modport sink (input valid, rx_level, send_valid, send_byte, output ready);
endinterface

interface u8t_result_if;
	logic       valid;
	logic       ready;
	logic       tx_level;
	logic       tx_busy;
	logic       recv_valid;
	logic [7:0] recv_byte;
	logic       frame_error;

	modport source (output valid, tx_level, tx_busy, recv_valid, recv_byte, frame_error,
		input ready);
	modport sink (input valid, tx_level, tx_busy, recv_valid, recv_byte, frame_error,
		output ready);
endinterface

// ===== rtl/u8t_tx.sv =====
// Transmitter of the 8N1 serial transceiver core: frame state and bit timing.
// Advances one tick per step and reports the line level after that tick.
// Depends on u8t_pkg.
module u8t_tx
	import u8t_pkg::*;
#(
	parameter int DATA_BITS = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic              send_valid,
	input  logic [BYTE_W-1:0] send_byte,
	input  logic [CPB_W-1:0]  cpb,
	output tx_res_t           res
);

	localparam logic [IDX_W-1:0] LAST_DATA = IDX_W'(DATA_BITS);
	localparam logic [IDX_W-1:0] STOP_IDX  = IDX_W'(DATA_BITS + 1);

	logic              active_q, active_d;
	logic [IDX_W-1:0]  idx_q, idx_d;
	logic [CPB_W-1:0]  tick_q, tick_d, tick_inc;
	logic [BYTE_W-1:0] shift_q, shift_d;
	logic [2:0]        bit_sel;

	always_comb begin
		active_d = active_q;
		idx_d    = idx_q;
		tick_d   = tick_q;
		shift_d  = shift_q;
		tick_inc = tick_q + CPB_W'(1);
		if (active_q) begin
			tick_d = tick_inc;
			if (tick_inc >= cpb) begin
				tick_d = '0;
				idx_d  = idx_q + IDX_W'(1);
				if (idx_q == STOP_IDX) begin
					active_d = 1'b0;
					idx_d    = '0;
				end
			end
		end else if (send_valid) begin
			active_d = 1'b1;
			idx_d    = '0;
			tick_d   = '0;
			shift_d  = send_byte;
		end

		bit_sel = 3'(idx_d - IDX_W'(1));
		res.busy = active_d;
		if (!active_d || idx_d > LAST_DATA) begin
			res.level = 1'b1;
		end else if (idx_d == '0) begin
			res.level = 1'b0;
		end else begin
			res.level = shift_d[bit_sel];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			idx_q    <= '0;
			tick_q   <= '0;
			shift_q  <= '0;
		end else if (step) begin
			active_q <= active_d;
			idx_q    <= idx_d;
			tick_q   <= tick_d;
			shift_q  <= shift_d;
		end
	end

endmodule

// ===== rtl/u8t_rx.sv =====
// Receiver of the 8N1 serial transceiver core: start detection, mid-bit
// sampling against a target recomputed each tick, and the byte report.
// Depends on u8t_pkg.
module u8t_rx
	import u8t_pkg::*;
#(
	parameter int DATA_BITS = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic             rx_level,
	input  logic [CPB_W-1:0] cpb,
	output rx_res_t          res
);

	localparam logic [IDX_W-1:0] LAST_DATA = IDX_W'(DATA_BITS);

	logic                   active_q, active_d;
	logic [ELAPSED_W-1:0]   elapsed_q, elapsed_d, elapsed_inc;
	logic [IDX_W-1:0]       idx_q, idx_d;
	logic [BYTE_W-1:0]      shift_q, shift_d;
	logic [IDX_W:0]         periods;
	logic [IDX_W+CPB_W:0]   product;
	logic [ELAPSED_W-1:0]   target;

	always_comb begin
		active_d  = active_q;
		elapsed_d = elapsed_q;
		idx_d     = idx_q;
		shift_d   = shift_q;
		res       = '0;

		elapsed_inc = (elapsed_q == ELAPSED_MAX) ? elapsed_q : elapsed_q + ELAPSED_W'(1);
		// Sample point of the current bit: whole periods to its start plus half a period.
		periods = {1'b0, idx_q} + (IDX_W+1)'(1);
		product = periods * cpb;
		target  = ELAPSED_W'(product) + ELAPSED_W'(cpb >> 1);

		if (!active_q) begin
			if (!rx_level) begin
				active_d  = 1'b1;
				elapsed_d = '0;
				idx_d     = '0;
				shift_d   = '0;
			end
		end else begin
			elapsed_d = elapsed_inc;
			if (elapsed_inc >= target) begin
				if (idx_q < LAST_DATA) begin
					shift_d[idx_q[2:0]] = shift_q[idx_q[2:0]] | rx_level;
					idx_d = idx_q + IDX_W'(1);
				end else begin
					res.valid = 1'b1;
					res.data  = shift_q;
					res.ferr  = !rx_level;
					active_d  = 1'b0;
					elapsed_d = '0;
					idx_d     = '0;
					shift_d   = '0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= 1'b0;
			elapsed_q <= '0;
			idx_q     <= '0;
			shift_q   <= '0;
		end else if (step) begin
			active_q  <= active_d;
			elapsed_q <= elapsed_d;
			idx_q     <= idx_d;
			shift_q   <= shift_d;
		end
	end

endmodule

// ===== rtl/uart_8n1_transceiver_core.sv =====
// 8N1 serial transceiver core: each input beat is one bit-timing tick and
// yields exactly one result beat. Depends on u8t_pkg, u8t_if, u8t_tx, u8t_rx.
//
// Every input beat carries the sampled receive line and an optional byte to
// send; every result beat gives the transmit line and busy flag after that
// tick plus, on the tick a stop bit is sampled, the received byte and a
// framing-error flag. A beat passes through an input register and a result
// register with one step of transmitter and receiver logic between them, so
// a new beat is taken every cycle unless the result side stalls. The longest
// path is the receiver's sample-point product of bit index and bit period
// followed by a 20-bit compare. The bit period is written through cfg_wr_en
// and cfg_wr_data and should only change while no beat is in flight; values
// below two act as two. A send request while a frame is going out is dropped.
module uart_8n1_transceiver_core
	import u8t_pkg::*;
#(
	parameter int DATA_BITS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [CPB_W-1:0]   cfg_wr_data,
	u8t_item_if.sink           item,
	u8t_result_if.source       result
);

	logic              valid_s1;
	logic              rx_level_s1;
	logic              send_valid_s1;
	logic [BYTE_W-1:0] send_byte_s1;

	logic              out_valid_q;
	tx_res_t           tx_res_q;
	rx_res_t           rx_res_q;

	logic [CPB_W-1:0]  cpb_q;
	logic [CPB_W-1:0]  cpb_eff;
	logic              advance;
	tx_res_t           tx_res;
	rx_res_t           rx_res;

	assign cpb_eff    = (cpb_q < CPB_MIN) ? CPB_MIN : cpb_q;
	assign advance    = valid_s1 && (!out_valid_q || result.ready);
	assign item.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cpb_q <= CPB_RESET;
		end else if (cfg_wr_en) begin
			cpb_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			rx_level_s1   <= item.rx_level;
			send_valid_s1 <= item.send_valid;
			send_byte_s1  <= item.send_byte;
		end
	end

	u8t_tx #(.DATA_BITS(DATA_BITS)) u_tx (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.send_valid (send_valid_s1),
		.send_byte  (send_byte_s1),
		.cpb        (cpb_eff),
		.res        (tx_res)
	);

	u8t_rx #(.DATA_BITS(DATA_BITS)) u_rx (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (advance),
		.rx_level (rx_level_s1),
		.cpb      (cpb_eff),
		.res      (rx_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			tx_res_q <= tx_res;
			rx_res_q <= rx_res;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.tx_level    = tx_res_q.level;
	assign result.tx_busy     = tx_res_q.busy;
	assign result.recv_valid  = rx_res_q.valid;
	assign result.recv_byte   = rx_res_q.data;
	assign result.frame_error = rx_res_q.ferr;

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for uart_8n1_transceiver_core: drives one tick per input beat and
// compares every result beat with a cycle-true prediction of the transmitter and receiver.
// Depends on u8t_pkg, the u8t_item_if/u8t_result_if interfaces and the core RTL.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import u8t_pkg::*;

	localparam int DATA_BITS       = 8;
	localparam int LIMIT_CYCLES    = 200000;
	localparam int HOLD_OFF_CYCLES = 300;

	typedef struct packed {
		logic              tx_level;
		logic              tx_busy;
		logic              recv_valid;
		logic [BYTE_W-1:0] recv_byte;
		logic              frame_error;
	} line_state_t;

	// Predicts the line state after each tick and checks result beats against it.
	class uart_tick_checker;
		logic [CPB_W-1:0]     period;
		logic                 tx_on;
		logic [IDX_W-1:0]     tx_bit;
		logic [CPB_W-1:0]     tx_ticks;
		logic [BYTE_W-1:0]    tx_data;
		logic                 rx_on;
		logic [ELAPSED_W-1:0] rx_ticks;
		logic [IDX_W-1:0]     rx_bit;
		logic [BYTE_W-1:0]    rx_data;
		line_state_t          expected_ticks[$];
		int                   errors;

		function new();
			period   = CPB_RESET;
			tx_on    = 1'b0;
			tx_bit   = '0;
			tx_ticks = '0;
			tx_data  = '0;
			rx_on    = 1'b0;
			rx_ticks = '0;
			rx_bit   = '0;
			rx_data  = '0;
			errors   = 0;
		endfunction

		function void note_tick(logic rx, logic req, logic [BYTE_W-1:0] data);
			logic [CPB_W-1:0] per;
			logic [31:0]      sample_at;
			line_state_t      r;
			per = (period < CPB_MIN) ? CPB_MIN : period;
			r = '0;

			if (tx_on) begin
				tx_ticks = tx_ticks + 1'b1;
				if (tx_ticks >= per) begin
					tx_ticks = '0;
					tx_bit = tx_bit + 1'b1;
					if (tx_bit > DATA_BITS + 1) begin
						tx_on = 1'b0;
						tx_bit = '0;
					end
				end
			end else if (req) begin
				tx_on = 1'b1;
				tx_bit = '0;
				tx_ticks = '0;
				tx_data = data;
			end

			if (!rx_on) begin
				if (!rx) begin
					rx_on = 1'b1;
					rx_ticks = '0;
					rx_bit = '0;
					rx_data = '0;
				end
			end else begin
				if (rx_ticks != ELAPSED_MAX)
					rx_ticks = rx_ticks + 1'b1;
				// Bit i is sampled in the middle of its period, counted from the start edge.
				sample_at = (32'(rx_bit) + 1) * 32'(per) + 32'(per) / 2;
				if (32'(rx_ticks) >= sample_at) begin
					if (rx_bit < DATA_BITS) begin
						rx_data[rx_bit[2:0]] = rx;
						rx_bit = rx_bit + 1'b1;
					end else begin
						r.recv_valid = 1'b1;
						r.recv_byte = rx_data;
						r.frame_error = !rx;
						rx_on = 1'b0;
						rx_ticks = '0;
						rx_bit = '0;
						rx_data = '0;
					end
				end
			end

			r.tx_busy = tx_on;
			if (!tx_on || tx_bit > DATA_BITS)
				r.tx_level = 1'b1;
			else if (tx_bit == 0)
				r.tx_level = 1'b0;
			else
				r.tx_level = tx_data[3'(tx_bit - 1'b1)];
			expected_ticks.push_back(r);
		endfunction

		function void compare_field(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				$error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
				errors++;
			end
		endfunction

		function void check_result(line_state_t got);
			line_state_t want;
			if (expected_ticks.size() == 0) begin
				$error("result beat with no tick outstanding");
				errors++;
				return;
			end
			want = expected_ticks.pop_front();
			compare_field("tx_level", want.tx_level, got.tx_level);
			compare_field("tx_busy", want.tx_busy, got.tx_busy);
			compare_field("recv_valid", want.recv_valid, got.recv_valid);
			compare_field("recv_byte", want.recv_byte, got.recv_byte);
			compare_field("frame_error", want.frame_error, got.frame_error);
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             cfg_wr_en;
	logic [CPB_W-1:0] cfg_wr_data;

	u8t_item_if   item_ch();
	u8t_result_if result_ch();

	uart_8n1_transceiver_core #(
		.DATA_BITS(DATA_BITS)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.item       (item_ch),
		.result     (result_ch)
	);

	uart_tick_checker sb = new();

	int               send_idle_pct = 0;
	int               stall_pct     = 0;
	int               hold_left     = 0;
	int unsigned      cycle_count   = 0;
	logic [CPB_W-1:0] bit_period    = CPB_RESET;
	bit               rx_wave[$];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("testbench: errors");
		$finish;
	end

	// Result side: random stalls, plus a long hold-off when one is requested.
	initial begin
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				result_ch.ready <= 1'b0;
				hold_left--;
			end else begin
				result_ch.ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready)
			sb.check_result(line_state_t'{
				tx_level:    result_ch.tx_level,
				tx_busy:     result_ch.tx_busy,
				recv_valid:  result_ch.recv_valid,
				recv_byte:   result_ch.recv_byte,
				frame_error: result_ch.frame_error});
	end

	// Next receive line level: mostly well-formed frames at the current bit period,
	// with bursts of noise and idle runs in between.
	function automatic logic next_rx_level();
		int unsigned       per;
		int unsigned       pick;
		logic [BYTE_W-1:0] data;
		if (rx_wave.size() == 0) begin
			per = (bit_period < CPB_MIN) ? CPB_MIN : bit_period;
			pick = $urandom_range(99);
			if (per <= 64 && pick < 75) begin
				data = BYTE_W'($urandom);
				repeat (per) rx_wave.push_back(1'b0);
				for (int i = 0; i < DATA_BITS; i++)
					repeat (per) rx_wave.push_back(data[i]);
				// A low stop bit now and then gives a framing error.
				repeat (per) rx_wave.push_back($urandom_range(99) >= 10);
				repeat ($urandom_range(2 * per)) rx_wave.push_back(1'b1);
			end else if (pick < 90) begin
				repeat ($urandom_range(1, 6)) rx_wave.push_back(1'($urandom));
			end else begin
				repeat ($urandom_range(1, 20)) rx_wave.push_back(1'b1);
			end
		end
		return rx_wave.pop_front();
	endfunction

	task automatic drive_tick(input logic rx, input logic req, input logic [BYTE_W-1:0] data);
		while ($urandom_range(99) < send_idle_pct) begin
			item_ch.valid      <= 1'b0;
			item_ch.rx_level   <= 1'($urandom);
			item_ch.send_valid <= 1'($urandom);
			item_ch.send_byte  <= BYTE_W'($urandom);
			@(posedge clk);
		end
		item_ch.valid      <= 1'b1;
		item_ch.rx_level   <= rx;
		item_ch.send_valid <= req;
		item_ch.send_byte  <= data;
		do @(posedge clk); while (!item_ch.ready);
		sb.note_tick(rx, req, data);
	endtask

	task automatic drain_results();
		item_ch.valid <= 1'b0;
		while (sb.expected_ticks.size() != 0) @(posedge clk);
	endtask

	// The period is changed only with no beat in flight; frame state carries over.
	task automatic start_phase(input logic [CPB_W-1:0] per, input int idle_pct, input int stall);
		drain_results();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= per;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.period = per;
		bit_period = per;
		rx_wave.delete();
		send_idle_pct = idle_pct;
		stall_pct = stall;
	endtask

	task automatic run_phase(input logic [CPB_W-1:0] per, input int n, input int idle_pct,
			input int stall, input bit hold);
		start_phase(per, idle_pct, stall);
		if (hold)
			hold_left = HOLD_OFF_CYCLES;
		repeat (n) drive_tick(next_rx_level(), $urandom_range(99) < 20, BYTE_W'($urandom));
	endtask

	initial begin
		arst_n             <= 1'b0;
		cfg_wr_en          <= 1'b0;
		cfg_wr_data        <= '0;
		item_ch.valid      <= 1'b0;
		item_ch.rx_level   <= 1'b1;
		item_ch.send_valid <= 1'b0;
		item_ch.send_byte  <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset period with an idle line, so no frame is left open.
		repeat (6) drive_tick(1'b1, 1'b0, '0);

		// A zero period acts as two. Send 0xFF, then a request while busy that must be
		// dropped. The line stays low through the stop sample, which reports a framing
		// error and re-arms straight into a new frame.
		start_phase('0, 0, 0);
		for (int i = 0; i < 25; i++)
			drive_tick(i >= 21, i < 2, (i == 0) ? 8'hFF : 8'h00);

		run_phase(16'd1, 120, 0, 0, 1'b0);
		run_phase(16'd2, 120, 55, 0, 1'b0);
		run_phase(16'd3, 120, 0, 55, 1'b0);
		run_phase(16'd5, 120, 34, 34, 1'b1);
		// Longest period leaves frames open; the next phase shortens it mid-frame.
		run_phase(16'hFFFF, 20, 0, 0, 1'b0);
		run_phase(16'd4, 150, 34, 34, 1'b0);
		run_phase(16'd7, 170, 0, 0, 1'b0);

		drain_results();
		repeat (4) @(posedge clk);
		if (sb.errors == 0 && sb.expected_ticks.size() == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule
